FILE: hw/rtl/ard_exponential_kernel_unit_assert.svh
// Assertion macros for the ard_ek block.
`ifndef ARD_EXPONENTIAL_KERNEL_UNIT_ASSERT_SVH
`define ARD_EXPONENTIAL_KERNEL_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ARD_EK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ARD_EK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define ARD_EK_ASSERT_NXT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ard_ek_pkg.sv
package ard_ek_pkg;

    localparam int NCOMP       = 4;
    localparam int DIM_DEFAULT = 4;
    localparam int XW          = 32;
    localparam int DW          = 33;
    localparam int INVW        = 24;
    localparam int SVW         = 32;
    localparam int IDXW        = 3;
    localparam int CFGW        = 32;
    localparam int SELW        = 2;

    localparam logic [IDXW-1:0] REG_INV_SCALE_0     = 3'd0;
    localparam logic [IDXW-1:0] REG_INV_SCALE_1     = 3'd1;
    localparam logic [IDXW-1:0] REG_INV_SCALE_2     = 3'd2;
    localparam logic [IDXW-1:0] REG_INV_SCALE_3     = 3'd3;
    localparam logic [IDXW-1:0] REG_SIGNAL_VARIANCE = 3'd4;
    localparam logic [IDXW-1:0] REG_ANGLE_INDEX     = 3'd5;
    localparam logic [IDXW-1:0] REG_WRAP_ENABLE     = 3'd6;

    localparam logic [INVW-1:0] INV_RESET = 24'd65536;
    localparam logic [SVW-1:0]  SV_RESET  = 32'd65536;

    localparam int TW          = 34;
    localparam int RMW         = 25;
    localparam int WRAP_STEPS  = 9;
    localparam longint ANGLE_HALF = 64'd180 * 64'd65536;
    localparam longint ANGLE_FULL = 64'd360 * 64'd65536;
    localparam longint WRAP_BIAS  = 64'd183 * ANGLE_FULL;

    localparam int PW          = 57;
    localparam int SW          = 23;
    localparam logic [SW-1:0] S_CLAMP = 23'd4194304;
    localparam int SQW         = 46;
    localparam int QW          = 48;
    localparam int ZW          = 24;
    localparam int SQRT_STAGES = 12;

    localparam int SERIES_TERMS = 12;
    localparam int FAR_LIMIT    = 23;
    localparam int TERMW        = 33;
    localparam int ACCW         = 35;
    localparam int NW           = 5;
    localparam int FRW          = 16;
    localparam int EW           = 33;
    localparam logic [30:0] EXP_NEG1 = 31'd1580030169;

    typedef logic [NCOMP-1:0][DW-1:0] lanes_t;

endpackage

FILE: hw/rtl/ard_ek_wrap.sv
module ard_ek_wrap (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  ard_ek_pkg::lanes_t              in_lanes,
    input  logic [ard_ek_pkg::SELW-1:0]     in_sel,
    input  logic                            in_on,
    output logic                            out_valid,
    output ard_ek_pkg::lanes_t              out_lanes
);

    localparam int TW    = ard_ek_pkg::TW;
    localparam int DW    = ard_ek_pkg::DW;
    localparam int NSTEP = ard_ek_pkg::WRAP_STEPS;

    typedef struct packed {
        logic                            valid;
        ard_ek_pkg::lanes_t              lanes;
        logic [ard_ek_pkg::SELW-1:0]     sel;
        logic                            on;
        logic [TW-1:0]                   t;
    } wst_t;

    wst_t st_reg [NSTEP+1];
    wst_t st0_next;
    logic signed [TW:0] t_wide;

    always_comb begin
        t_wide = $signed({{(TW+1-DW){in_lanes[in_sel][DW-1]}}, in_lanes[in_sel]})
               + $signed((TW+1)'(ard_ek_pkg::ANGLE_HALF + ard_ek_pkg::WRAP_BIAS));
        st0_next.valid = in_valid;
        st0_next.lanes = in_lanes;
        st0_next.sel   = in_sel;
        st0_next.on    = in_on;
        st0_next.t     = t_wide[TW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar j = 1; j <= NSTEP; j++) begin : g_step
        localparam logic [TW-1:0] SUB = TW'(ard_ek_pkg::ANGLE_FULL) << (NSTEP - j);
        wst_t st_next;
        always_comb begin
            st_next = st_reg[j-1];
            if (st_reg[j-1].t >= SUB) begin
                st_next.t = st_reg[j-1].t - SUB;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[j].valid <= 1'b0;
            end else if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    logic               out_valid_reg;
    ard_ek_pkg::lanes_t out_lanes_reg;
    ard_ek_pkg::lanes_t out_lanes_next;

    always_comb begin
        out_lanes_next = st_reg[NSTEP].lanes;
        if (st_reg[NSTEP].on) begin
            out_lanes_next[st_reg[NSTEP].sel] =
                DW'(st_reg[NSTEP].t[ard_ek_pkg::RMW-1:0]) - DW'(ard_ek_pkg::ANGLE_HALF);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= st_reg[NSTEP].valid;
            out_lanes_reg <= out_lanes_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_lanes = out_lanes_reg;

endmodule

FILE: hw/rtl/ard_ek_sqrt.sv
module ard_ek_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ard_ek_pkg::QW-1:0]   in_q,
    output logic                        out_valid,
    output logic [ard_ek_pkg::ZW-1:0]   out_z
);

    localparam int QW = ard_ek_pkg::QW;
    localparam int ZW = ard_ek_pkg::ZW;
    localparam int RW = 28;
    localparam int NS = ard_ek_pkg::SQRT_STAGES;

    typedef struct packed {
        logic          valid;
        logic [QW-1:0] q;
        logic [RW-1:0] rem;
        logic [ZW-1:0] root;
    } sst_t;

    sst_t st_reg [NS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (en) begin
            st_reg[0].valid <= in_valid;
            st_reg[0].q     <= in_q;
            st_reg[0].rem   <= '0;
            st_reg[0].root  <= '0;
        end
    end

    for (genvar g = 1; g <= NS; g++) begin : g_stage
        localparam int BH = 2 * (NS - g) + 1;
        localparam int BL = BH - 1;
        sst_t st_next;
        logic [RW-1:0] rem_a, rem_b, trial_a, trial_b;
        logic [ZW-1:0] root_a;
        always_comb begin
            st_next = st_reg[g-1];
            rem_a   = {st_reg[g-1].rem[RW-3:0], st_reg[g-1].q[2*BH+1], st_reg[g-1].q[2*BH]};
            trial_a = {2'b00, st_reg[g-1].root, 2'b01};
            if (rem_a >= trial_a) begin
                rem_a  = rem_a - trial_a;
                root_a = {st_reg[g-1].root[ZW-2:0], 1'b1};
            end else begin
                root_a = {st_reg[g-1].root[ZW-2:0], 1'b0};
            end
            rem_b   = {rem_a[RW-3:0], st_reg[g-1].q[2*BL+1], st_reg[g-1].q[2*BL]};
            trial_b = {2'b00, root_a, 2'b01};
            if (rem_b >= trial_b) begin
                st_next.rem  = rem_b - trial_b;
                st_next.root = {root_a[ZW-2:0], 1'b1};
            end else begin
                st_next.rem  = rem_b;
                st_next.root = {root_a[ZW-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[g].valid <= 1'b0;
            end else if (en) begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign out_valid = st_reg[NS].valid;
    assign out_z     = st_reg[NS].root;

endmodule

FILE: hw/rtl/ard_ek_exp.sv
module ard_ek_exp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ard_ek_pkg::ZW-1:0]   in_z,
    input  logic [ard_ek_pkg::SVW-1:0]  sv,
    output logic                        out_valid,
    output logic [ard_ek_pkg::SVW-1:0]  out_cov
);

    localparam int TERMW = ard_ek_pkg::TERMW;
    localparam int ACCW  = ard_ek_pkg::ACCW;
    localparam int NW    = ard_ek_pkg::NW;
    localparam int FRW   = ard_ek_pkg::FRW;
    localparam int EW    = ard_ek_pkg::EW;
    localparam int SVW   = ard_ek_pkg::SVW;
    localparam int NSER  = 3 * ard_ek_pkg::SERIES_TERMS;
    localparam int NPOW  = ard_ek_pkg::FAR_LIMIT - 1;

    typedef struct packed {
        logic                   valid;
        logic                   far;
        logic [NW-1:0]          n;
        logic [FRW-1:0]         fr;
        logic [TERMW-1:0]       term;
        logic [TERMW-1:0]       prod;
        logic [TERMW-1:0]       quo;
        logic signed [ACCW-1:0] acc;
    } ser_st_t;

    typedef struct packed {
        logic          valid;
        logic          far;
        logic [NW-1:0] n;
        logic [EW-1:0] e;
    } pow_st_t;

    ser_st_t st_reg [NSER+1];
    pow_st_t pw_reg [NPOW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (en) begin
            st_reg[0].valid <= in_valid;
            st_reg[0].far   <= (in_z[ard_ek_pkg::ZW-1:FRW] >= 8'(ard_ek_pkg::FAR_LIMIT));
            st_reg[0].n     <= in_z[FRW+NW-1:FRW];
            st_reg[0].fr    <= in_z[FRW-1:0];
            st_reg[0].term  <= TERMW'(1) << 32;
            st_reg[0].prod  <= '0;
            st_reg[0].quo   <= '0;
            st_reg[0].acc   <= ACCW'(1) << 32;
        end
    end

    for (genvar j = 1; j <= NSER; j++) begin : g_ser
        localparam int unsigned K  = (j - 1) / 3 + 1;
        localparam int          PH = (j - 1) % 3;
        localparam logic [32:0] M  = 33'((64'd1 << 33) / K);
        ser_st_t st_next;
        logic [48:0] pr;
        logic [65:0] y;
        logic [TERMW-1:0] r, q;
        always_comb begin
            st_next = st_reg[j-1];
            pr = st_reg[j-1].term * st_reg[j-1].fr;
            y  = st_reg[j-1].prod * M;
            r  = st_reg[j-1].prod - TERMW'(st_reg[j-1].quo * K);
            q  = (r >= TERMW'(K)) ? st_reg[j-1].quo + TERMW'(1) : st_reg[j-1].quo;
            case (PH)
                0: st_next.prod = pr[48:16];
                1: st_next.quo  = (K == 1) ? st_reg[j-1].prod : y[65:33];
                2: begin
                    st_next.term = q;
                    if (K % 2 == 1) begin
                        st_next.acc = st_reg[j-1].acc - $signed({2'b00, q});
                    end else begin
                        st_next.acc = st_reg[j-1].acc + $signed({2'b00, q});
                    end
                end
                default: st_next = st_reg[j-1];
            endcase
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[j].valid <= 1'b0;
            end else if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    pow_st_t pw0_next;

    always_comb begin
        pw0_next.valid = st_reg[NSER].valid;
        pw0_next.far   = st_reg[NSER].far;
        pw0_next.n     = st_reg[NSER].n;
        if (st_reg[NSER].acc < 0) begin
            pw0_next.e = '0;
        end else if (st_reg[NSER].acc > $signed(ACCW'(1) << 32)) begin
            pw0_next.e = EW'(1) << 32;
        end else begin
            pw0_next.e = st_reg[NSER].acc[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg[0].valid <= 1'b0;
        end else if (en) begin
            pw_reg[0] <= pw0_next;
        end
    end

    for (genvar i = 1; i <= NPOW; i++) begin : g_pow
        pow_st_t pw_next;
        logic [63:0] y;
        always_comb begin
            pw_next = pw_reg[i-1];
            y = pw_reg[i-1].e * ard_ek_pkg::EXP_NEG1;
            if (NW'(i - 1) < pw_reg[i-1].n) begin
                pw_next.e = EW'(y[63:32]);
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_reg[i].valid <= 1'b0;
            end else if (en) begin
                pw_reg[i] <= pw_next;
            end
        end
    end

    logic            out_valid_reg;
    logic [SVW-1:0]  out_cov_reg;
    logic [SVW-1:0]  out_cov_next;
    logic [64:0]     cp;

    always_comb begin
        cp = sv * pw_reg[NPOW].e;
        if (pw_reg[NPOW].far) begin
            out_cov_next = '0;
        end else if (cp[64]) begin
            out_cov_next = '1;
        end else begin
            out_cov_next = cp[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= pw_reg[NPOW].valid;
            out_cov_reg   <= out_cov_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cov   = out_cov_reg;

endmodule

FILE: hw/rtl/ard_exponential_kernel_unit.sv
// Channel   Dir  Ports                         Word
// --------  ---  ----------------------------  ------------------------------------
// s_        in   s_tvalid s_tready s_tdata     point pair, 8 x 32 bit
// m_        out  m_tvalid m_tready m_tdata     covariance, 32 bit
// cfg_      in   cfg_we cfg_index cfg_data     register write, no wait
//
// One word enters per cycle while the pipeline advances; each word passes, in order,
// through the diff, wrap, scale and sum, square root (two root bits per stage),
// series, exp(-1) powers and amplitude stages.
// The whole pipeline advances whenever the output register is empty or taken;
// s_tready follows the same condition.
// Reset clears the valid bits and loads the register defaults.
module ard_exponential_kernel_unit #(
    parameter int DIM = ard_ek_pkg::DIM_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x1_0, x1_1, x1_2, x1_3, x2_0, x2_1, x2_2, x2_3 (32 bit each)
    input  logic [255:0]                   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // covariance
    output logic [31:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [ard_ek_pkg::IDXW-1:0]    cfg_index,
    input  logic [ard_ek_pkg::CFGW-1:0]    cfg_data
);

    localparam int NCOMP = ard_ek_pkg::NCOMP;
    localparam int LANES = (DIM < NCOMP) ? DIM : NCOMP;
    localparam int XW    = ard_ek_pkg::XW;
    localparam int DW    = ard_ek_pkg::DW;
    localparam int INVW  = ard_ek_pkg::INVW;
    localparam int PW    = ard_ek_pkg::PW;
    localparam int SW    = ard_ek_pkg::SW;
    localparam int SQW   = ard_ek_pkg::SQW;
    localparam int QW    = ard_ek_pkg::QW;

    logic [INVW-1:0]                 inv_scale_reg [NCOMP];
    logic [ard_ek_pkg::SVW-1:0]      sv_reg;
    logic [ard_ek_pkg::SELW-1:0]     angle_index_reg;
    logic                            wrap_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOMP; i++) begin
                inv_scale_reg[i] <= ard_ek_pkg::INV_RESET;
            end
            sv_reg          <= ard_ek_pkg::SV_RESET;
            angle_index_reg <= '0;
            wrap_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                ard_ek_pkg::REG_INV_SCALE_0:     inv_scale_reg[0] <= cfg_data[INVW-1:0];
                ard_ek_pkg::REG_INV_SCALE_1:     inv_scale_reg[1] <= cfg_data[INVW-1:0];
                ard_ek_pkg::REG_INV_SCALE_2:     inv_scale_reg[2] <= cfg_data[INVW-1:0];
                ard_ek_pkg::REG_INV_SCALE_3:     inv_scale_reg[3] <= cfg_data[INVW-1:0];
                ard_ek_pkg::REG_SIGNAL_VARIANCE: sv_reg <= cfg_data;
                ard_ek_pkg::REG_ANGLE_INDEX:     angle_index_reg <= cfg_data[1:0];
                ard_ek_pkg::REG_WRAP_ENABLE:     wrap_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid;

    logic               d_valid_reg;
    ard_ek_pkg::lanes_t d_reg;
    ard_ek_pkg::lanes_t d_next;

    always_comb begin
        d_next = '0;
        for (int i = 0; i < LANES; i++) begin
            d_next[i] = $signed({s_tdata[XW*i+XW-1], s_tdata[XW*i +: XW]})
                      - $signed({s_tdata[XW*(NCOMP+i)+XW-1], s_tdata[XW*(NCOMP+i) +: XW]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= s_tvalid;
            d_reg       <= d_next;
        end
    end

    logic               w_valid;
    ard_ek_pkg::lanes_t w_lanes;
    logic               wrap_on;

    assign wrap_on = wrap_enable_reg && (int'(angle_index_reg) < LANES);

    ard_ek_wrap u_wrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_lanes  (d_reg),
        .in_sel    (angle_index_reg),
        .in_on     (wrap_on),
        .out_valid (w_valid),
        .out_lanes (w_lanes)
    );

    logic           p_valid_reg, c_valid_reg, q_valid_reg, sum_valid_reg;
    logic [PW-1:0]  prod_reg [NCOMP];
    logic [SW-1:0]  sc_reg   [NCOMP];
    logic [SQW-1:0] sq_reg   [NCOMP];
    logic [QW-1:0]  qsum_reg;
    logic [PW-1:0]  prod_next [NCOMP];
    logic [SW-1:0]  sc_next   [NCOMP];
    logic [DW-1:0]  mag;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            mag = w_lanes[i][DW-1] ? DW'(-w_lanes[i]) : w_lanes[i];
            prod_next[i] = mag * inv_scale_reg[i];
            if (prod_reg[i][PW-1:16] > (PW-16)'(ard_ek_pkg::S_CLAMP)) begin
                sc_next[i] = ard_ek_pkg::S_CLAMP;
            end else begin
                sc_next[i] = prod_reg[i][SW+15:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg   <= w_valid;
            c_valid_reg   <= p_valid_reg;
            q_valid_reg   <= c_valid_reg;
            sum_valid_reg <= q_valid_reg;
            for (int i = 0; i < NCOMP; i++) begin
                prod_reg[i] <= prod_next[i];
                sc_reg[i]   <= sc_next[i];
                sq_reg[i]   <= sc_reg[i] * sc_reg[i];
            end
            qsum_reg <= (QW'(sq_reg[0]) + QW'(sq_reg[1])) + (QW'(sq_reg[2]) + QW'(sq_reg[3]));
        end
    end

    logic                        z_valid;
    logic [ard_ek_pkg::ZW-1:0]   z;

    ard_ek_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sum_valid_reg),
        .in_q      (qsum_reg),
        .out_valid (z_valid),
        .out_z     (z)
    );

    ard_ek_exp u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (z_valid),
        .in_z      (z),
        .sv        (sv_reg),
        .out_valid (out_valid),
        .out_cov   (m_tdata)
    );

endmodule

FILE: hw/rtl/ard_ek_checker.sv
`include "ard_exponential_kernel_unit_assert.svh"

module ard_ek_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `ARD_EK_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `ARD_EK_ASSERT_IMP(a_back_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `ARD_EK_ASSERT_IMP(a_idle_ready, aclk, aresetn, !m_tvalid, s_tready, "input refused with empty output")
    `ARD_EK_ASSERT_NXT_RAW(a_reset_empty, aclk, !aresetn, !m_tvalid, "output valid right after reset")

endmodule

bind ard_exponential_kernel_unit ard_ek_checker u_ard_ek_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/ard_ek_checker.sv
`timescale 1ns / 1ps

module ard_ek_scoreboard (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [255:0]                s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [31:0]                 m_tdata,
    input  logic                        cfg_we,
    input  logic [ard_ek_pkg::IDXW-1:0] cfg_index,
    input  logic [ard_ek_pkg::CFGW-1:0] cfg_data,
    output int                          fail_count,
    output int                          pending
);

    localparam longint HALF_TURN = 180 * 65536;
    localparam longint FULL_TURN = 360 * 65536;
    localparam logic [63:0] NEG1_Q32 = 64'd1580030169;
    localparam logic [63:0] SCALED_MAX = 64'd1 << 22;

    logic [23:0] scale_r [ard_ek_pkg::NCOMP];
    logic [31:0] amp_r;
    logic [1:0]  angle_sel;
    logic        wrap_on;
    logic [31:0] cov_q [$];

    function automatic logic [31:0] covariance_of(input logic [255:0] w);
        longint      d;
        longint      r;
        longint      acc;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] term;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] e;
        logic [63:0] cov;
        q = 0;
        for (int i = 0; i < ard_ek_pkg::NCOMP; i++) begin
            d = longint'($signed(w[32*i +: 32])) - longint'($signed(w[128 + 32*i +: 32]));
            if (wrap_on && angle_sel == i) begin
                r = (d + HALF_TURN) % FULL_TURN;
                if (r < 0) r = r + FULL_TURN;
                d = r - HALF_TURN;
            end
            a = (d < 0) ? 64'(-d) : 64'(d);
            s = (a * 64'(scale_r[i])) >> 16;
            if (s > SCALED_MAX) s = SCALED_MAX;
            q = q + s * s;
        end
        root = 0;
        for (int b = 23; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= q) root = cand;
        end
        n = root >> 16;
        f = (root & 64'hFFFF) << 16;
        if (n >= 23) return 32'd0;
        term = 64'd1 << 32;
        acc = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * f) >> 32) / k;
            if (k % 2) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 32)) acc = longint'(1) << 32;
        e = 64'(acc);
        for (int i = 0; i < n; i++) e = (e * NEG1_Q32) >> 32;
        cov = (64'(amp_r) * e) >> 32;
        if (cov > 64'hFFFFFFFF) cov = 64'hFFFFFFFF;
        return cov[31:0];
    endfunction

    assign pending = cov_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ard_ek_pkg::NCOMP; i++) scale_r[i] <= ard_ek_pkg::INV_RESET;
            amp_r      <= ard_ek_pkg::SV_RESET;
            angle_sel  <= '0;
            wrap_on    <= 1'b0;
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) cov_q.push_back(covariance_of(s_tdata));
            if (m_tvalid && m_tready) begin
                if (cov_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    if (cov_q[0] !== m_tdata) begin
                        $display("%0t: covariance mismatch, expected %h, actual %h",
                                 $time, cov_q[0], m_tdata);
                        fail_count <= fail_count + 1;
                    end
                    void'(cov_q.pop_front());
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    ard_ek_pkg::REG_INV_SCALE_0: scale_r[0] <= cfg_data[23:0];
                    ard_ek_pkg::REG_INV_SCALE_1: scale_r[1] <= cfg_data[23:0];
                    ard_ek_pkg::REG_INV_SCALE_2: scale_r[2] <= cfg_data[23:0];
                    ard_ek_pkg::REG_INV_SCALE_3: scale_r[3] <= cfg_data[23:0];
                    ard_ek_pkg::REG_SIGNAL_VARIANCE: amp_r <= cfg_data;
                    ard_ek_pkg::REG_ANGLE_INDEX: angle_sel <= cfg_data[1:0];
                    ard_ek_pkg::REG_WRAP_ENABLE: wrap_on <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int IW = ard_ek_pkg::IDXW;
    localparam int CW = ard_ek_pkg::CFGW;
    localparam int NC = ard_ek_pkg::NCOMP;
    localparam logic [IW-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 120;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [255:0]        s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                cfg_we = 1'b0;
    logic [IW-1:0]       cfg_index = '0;
    logic [CW-1:0]       cfg_data = '0;
    int                  fail_count;
    int                  pending;

    int tx_pct = 0;
    int rx_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    ard_exponential_kernel_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ard_ek_scoreboard u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic send_word(input logic [255:0] w);
        if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_pair(input logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3);
        send_word({b3, b2, b1, b0, a3, a2, a1, a0});
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [255:0] random_word();
        logic [255:0] w;
        logic [31:0]  x1;
        logic [31:0]  delta;
        for (int i = 0; i < NC; i++) begin
            x1 = $urandom;
            case ($urandom_range(9))
                0: delta = $urandom;
                1: delta = $urandom_range(3) * 32'd23592960 + ($urandom_range(1) ? 0 : $urandom_range(255));
                default: delta = $signed($urandom) >>> $urandom_range(31, 8);
            endcase
            w[32*i +: 32] = x1;
            w[128 + 32*i +: 32] = x1 - delta;
        end
        return w;
    endfunction

    task automatic random_config();
        for (int i = 0; i < NC; i++)
            write_reg(IW'(ard_ek_pkg::REG_INV_SCALE_0 + i),
                      $urandom & ((32'd1 << $urandom_range(24, 1)) - 1));
        write_reg(ard_ek_pkg::REG_SIGNAL_VARIANCE, $urandom);
        write_reg(ard_ek_pkg::REG_ANGLE_INDEX, $urandom);
        write_reg(ard_ek_pkg::REG_WRAP_ENABLE, $urandom);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_pair(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h00010000, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h00168000, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h00170000, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h12345678, 32'hDEADBEEF, 32'h0BADF00D, 32'h55AA55AA,
                  32'h12345678, 32'hDEADBEEF, 32'h0BADF00D, 32'h55AA55AA);
        drain();

        write_reg(ard_ek_pkg::REG_WRAP_ENABLE, 1);
        for (int k = 0; k < NC; k++) begin
            write_reg(ard_ek_pkg::REG_ANGLE_INDEX, k);
            send_pair(32'h00B40000, 32'h00B40000, 32'h00B40000, 32'h00B40000, 0, 0, 0, 0);
            send_pair(32'hFF4C0000, 32'hFF4C0000, 32'hFF4C0000, 32'hFF4C0000, 0, 0, 0, 0);
            send_pair(32'h01680000, 32'h01680000, 32'h01680000, 32'h01680000, 0, 0, 0, 0);
            drain();
        end
        send_pair(32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 0, 0);
        drain();
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        write_reg(ard_ek_pkg::REG_SIGNAL_VARIANCE, 32'hFFFFFFFF);
        for (int i = 0; i < NC; i++) write_reg(IW'(ard_ek_pkg::REG_INV_SCALE_0 + i), 0);
        send_pair(32'h7FFFFFFF, 1, 2, 3, 32'h80000000, 4, 5, 6);
        drain();
        write_reg(ard_ek_pkg::REG_SIGNAL_VARIANCE, 0);
        for (int i = 0; i < NC; i++)
            write_reg(IW'(ard_ek_pkg::REG_INV_SCALE_0 + i), 32'h00FFFFFF);
        send_pair(1, 0, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(ard_ek_pkg::REG_SIGNAL_VARIANCE, 32'hFFFFFFFF);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 1, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 77; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 77; end
                default: begin tx_pct = 21; rx_pct = 21; end
            endcase
            if (ph == 11) begin
                for (int i = 0; i < NC; i++)
                    write_reg(IW'(ard_ek_pkg::REG_INV_SCALE_0 + i), 32'h00FFFFFF);
                write_reg(ard_ek_pkg::REG_SIGNAL_VARIANCE, 32'hFFFFFFFF);
            end else if (ph != 0) begin
                random_config();
            end
            if (ph == 4) begin
                tx_pct = 0;
                hold_reqs = hold_reqs + 1;
                for (int j = 0; j < 200; j++) send_word(random_word());
            end
            for (int j = 0; j < 45; j++) send_word(random_word());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
